/* rtl/irc_tok_pkg.sv */
// Shared types and constants for the IRC message tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package irc_tok_pkg;

  // Highest parameter index; the parameter counter stops here.
  localparam int MAX_PARAM_INDEX = 15;
  localparam int PCNT_W          = $clog2(MAX_PARAM_INDEX + 1);
  localparam int IDX_W           = 4;

  // Item field widths.
  localparam int BYTE_W  = 8;
  localparam int CLASS_W = 3;

  // Characters that steer the grammar.
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  // Byte classes reported with each result.
  typedef enum logic [CLASS_W-1:0] {
    CL_PREFIX  = 3'd0,
    CL_COMMAND = 3'd1,
    CL_MIDDLE  = 3'd2,
    CL_TRAIL   = 3'd3,
    CL_DELIM   = 3'd4
  } byte_class_t;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_PREFIX  = 6'b000010,
    PH_COMMAND = 6'b000100,
    PH_PSTART  = 6'b001000,
    PH_MIDDLE  = 6'b010000,
    PH_TRAIL   = 6'b100000
  } phase_t;

endpackage

`default_nettype wire

/* rtl/irc_message_tokenizer_top.sv */
// Top level of the IRC message tokenizer: classifies one line byte per item.
//
//  Channel  Direction  tdata                              tuser / tlast
//  s_*      in         [7:0] char_byte                    tlast = line_end
//  m_*      out        [7:0] byte_out, [11:8] param_index tuser [2:0] byte_class,
//                                                         [3] field_end, [4] line_ok;
//                                                         tlast = last
//
// One item per clock unless the output stalls: the byte is classified by the
// phase logic and written to the result register in the cycle it is accepted.
// The result register is the only stage; a new item is taken whenever that
// register is empty or is being drained in the same cycle.
// Synchronous reset returns the parser to line start and empties the result.
// A stalled output holds its result and stalls the input side.
`timescale 1ns / 1ps
`default_nettype none

module irc_message_tokenizer_top
  import irc_tok_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
  input  wire logic        s_tlast,   // line_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] byte_out, [11:8] param_index, [15:12] zero
  output logic [4:0]       m_tuser,   // [2:0] byte_class, [3] field_end, [4] line_ok
  output logic             m_tlast    // last
);

  // Parser state.
  phase_t              phase, phase_next;
  logic [PCNT_W-1:0]   param_count, param_count_next;
  logic                command_seen, command_seen_next;

  // Result register.
  logic                out_valid;
  logic [BYTE_W-1:0]   byte_out;
  byte_class_t         byte_class, byte_class_next;
  logic [IDX_W-1:0]    param_index, param_index_next;
  logic                field_end, field_end_next;
  logic                last;
  logic                line_ok;

  logic                accept;
  logic                is_colon, is_space;
  logic [PCNT_W-1:0]   param_count_inc;
  logic [IDX_W+PCNT_W-1:0] idx_wide;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_colon = (s_tdata == CH_COLON);
  assign is_space = (s_tdata == CH_SPACE);

  // Saturating advance of the parameter index.
  assign param_count_inc = (param_count == PCNT_W'(MAX_PARAM_INDEX)) ?
                           param_count : param_count + PCNT_W'(1);
  assign idx_wide = {{IDX_W{1'b0}}, param_count};

  // Classification and next phase for the byte on the input.
  always_comb begin
    phase_next        = phase;
    param_count_next  = param_count;
    command_seen_next = command_seen;
    byte_class_next   = CL_DELIM;
    param_index_next  = '0;
    field_end_next    = 1'b0;
    unique case (phase)
      PH_START: begin
        if (is_colon) begin
          phase_next = PH_PREFIX;
        end else if (is_space) begin
          field_end_next = 1'b1;
          phase_next     = PH_PSTART;
        end else begin
          byte_class_next   = CL_COMMAND;
          command_seen_next = 1'b1;
          phase_next        = PH_COMMAND;
        end
      end
      PH_PREFIX: begin
        if (is_space) begin
          field_end_next = 1'b1;
          phase_next     = PH_COMMAND;
        end else begin
          byte_class_next = CL_PREFIX;
        end
      end
      PH_COMMAND: begin
        if (is_space) begin
          field_end_next = 1'b1;
          phase_next     = PH_PSTART;
        end else begin
          byte_class_next   = CL_COMMAND;
          command_seen_next = 1'b1;
        end
      end
      PH_PSTART: begin
        param_index_next = idx_wide[IDX_W-1:0];
        if (is_colon) begin
          phase_next = PH_TRAIL;
        end else if (is_space) begin
          field_end_next   = 1'b1;
          param_count_next = param_count_inc;
        end else begin
          byte_class_next = CL_MIDDLE;
          phase_next      = PH_MIDDLE;
        end
      end
      PH_MIDDLE: begin
        param_index_next = idx_wide[IDX_W-1:0];
        if (is_space) begin
          field_end_next   = 1'b1;
          param_count_next = param_count_inc;
          phase_next       = PH_PSTART;
        end else begin
          byte_class_next = CL_MIDDLE;
        end
      end
      PH_TRAIL: begin
        param_index_next = idx_wide[IDX_W-1:0];
        byte_class_next  = CL_TRAIL;
      end
      default: begin
        phase_next = PH_START;
      end
    endcase
  end

  // Parser state; the final byte of a line returns it to line start.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      param_count  <= '0;
      command_seen <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        phase        <= PH_START;
        param_count  <= '0;
        command_seen <= 1'b0;
      end else begin
        phase        <= phase_next;
        param_count  <= param_count_next;
        command_seen <= command_seen_next;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_out    <= s_tdata;
      byte_class  <= byte_class_next;
      param_index <= param_index_next;
      field_end   <= field_end_next;
      last        <= s_tlast;
      line_ok     <= s_tlast && command_seen_next;
    end
  end

  // Output packing.
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(16 - IDX_W - BYTE_W){1'b0}}, param_index, byte_out};
  assign m_tuser  = {line_ok, field_end, byte_class};
  assign m_tlast  = last;

`ifndef SYNTH
  // The final byte of a line leaves the parser at line start.
  a_line_reset: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (phase == PH_START && param_count == '0 && !command_seen))
    else $error("parser state not cleared after line end");

  // line_ok appears only on the last result of a line.
  a_ok_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_ok) |-> last)
    else $error("line_ok without last");

  // A field end is always a space consumed as a delimiter.
  a_fend_space: assert property (@(posedge clk) disable iff (rst)
    (out_valid && field_end) |-> (byte_class == CL_DELIM && byte_out == CH_SPACE))
    else $error("field_end on a byte that is not a delimiting space");

  // A nonzero index belongs only to the parameter part of the line.
  a_idx_param: assert property (@(posedge clk) disable iff (rst)
    (out_valid && param_index != '0) |->
      (byte_class == CL_MIDDLE || byte_class == CL_TRAIL || byte_class == CL_DELIM))
    else $error("parameter index on a prefix or command byte");
`endif

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the IRC message tokenizer top level.
`timescale 1ns / 1ps

module testbench;
  import irc_tok_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;

  // One octet of a line as offered on the input stream.
  typedef struct packed {
    logic [7:0] octet;
    logic       eol;
  } line_octet_t;

  // Classification expected for one octet.
  typedef struct packed {
    logic [7:0]  octet;
    byte_class_t cls;
    logic [3:0]  pidx;
    logic        fend;
    logic        eol;
    logic        ok;
  } octet_class_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;

  line_octet_t  line_q[$];
  octet_class_t class_q[$];

  // Parser state tracked alongside the block.
  phase_t     tok_phase    = PH_START;
  logic [3:0] tok_pcount   = 4'd0;
  logic       tok_cmd_seen = 1'b0;

  int  n_total     = 0;
  int  accepted    = 0;
  int  mism_cnt    = 0;
  int  cycle_cnt   = 0;
  int  hold_cycles = 0;
  bit  hold_done   = 1'b0;
  bit  pausing     = 1'b0;
  bit  pause_done  = 1'b0;

  irc_message_tokenizer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Step the parser by one octet and return its classification.
  function automatic octet_class_t classify_octet(input logic [7:0] c, input logic eol);
    octet_class_t r;
    r.octet = c;
    r.cls   = CL_COMMAND;
    r.pidx  = 4'd0;
    r.fend  = 1'b0;
    r.eol   = eol;
    r.ok    = 1'b0;
    case (tok_phase)
      PH_START: begin
        if (c == CH_COLON) begin
          r.cls     = CL_DELIM;
          tok_phase = PH_PREFIX;
        end else if (c == CH_SPACE) begin
          r.cls     = CL_DELIM;
          r.fend    = 1'b1;
          tok_phase = PH_PSTART;
        end else begin
          tok_cmd_seen = 1'b1;
          tok_phase    = PH_COMMAND;
        end
      end
      PH_PREFIX: begin
        if (c == CH_SPACE) begin
          r.cls     = CL_DELIM;
          r.fend    = 1'b1;
          tok_phase = PH_COMMAND;
        end else begin
          r.cls = CL_PREFIX;
        end
      end
      PH_COMMAND: begin
        if (c == CH_SPACE) begin
          r.cls     = CL_DELIM;
          r.fend    = 1'b1;
          tok_phase = PH_PSTART;
        end else begin
          tok_cmd_seen = 1'b1;
        end
      end
      PH_PSTART: begin
        r.pidx = tok_pcount;
        if (c == CH_COLON) begin
          r.cls     = CL_DELIM;
          tok_phase = PH_TRAIL;
        end else if (c == CH_SPACE) begin
          r.cls  = CL_DELIM;
          r.fend = 1'b1;
          if (tok_pcount < MAX_PARAM_INDEX) tok_pcount++;
        end else begin
          r.cls     = CL_MIDDLE;
          tok_phase = PH_MIDDLE;
        end
      end
      PH_MIDDLE: begin
        r.pidx = tok_pcount;
        if (c == CH_SPACE) begin
          r.cls     = CL_DELIM;
          r.fend    = 1'b1;
          tok_phase = PH_PSTART;
          if (tok_pcount < MAX_PARAM_INDEX) tok_pcount++;
        end else begin
          r.cls = CL_MIDDLE;
        end
      end
      default: begin
        r.pidx    = tok_pcount;
        r.cls     = CL_TRAIL;
        tok_phase = PH_TRAIL;
      end
    endcase
    // The final octet reports the command status and rearms the parser.
    if (eol) begin
      r.ok         = tok_cmd_seen;
      tok_phase    = PH_START;
      tok_pcount   = 4'd0;
      tok_cmd_seen = 1'b0;
    end
    return r;
  endfunction

  // Idle percentage per side: sender light first, then swapped, then none.
  function automatic int idle_pct(input bit sender);
    if (accepted < n_total / 3) return sender ? 29 : 57;
    if (accepted < 2 * n_total / 3) return sender ? 57 : 29;
    return 0;
  endfunction

  // Any octet but a space, optionally also not a colon.
  function automatic logic [7:0] solid_octet(input bit no_colon);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_SPACE || (no_colon && b == CH_COLON));
    return b;
  endfunction

  task automatic push_octet(input logic [7:0] b, input logic eol);
    line_q.push_back('{b, eol});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_octet(s[i], i == s.len() - 1);
  endtask

  // Mostly well-formed lines with random content, the rest noise.
  task automatic push_random_line();
    logic [7:0] ln[$];
    int n;
    int n_par;
    if ($urandom_range(0, 99) < 80) begin
      if ($urandom_range(0, 1) == 1) begin
        ln.push_back(CH_COLON);
        n = $urandom_range(0, 6);
        repeat (n) ln.push_back(solid_octet(1'b0));
        ln.push_back(CH_SPACE);
      end
      n = $urandom_range(1, 5);
      ln.push_back(solid_octet(1'b1));
      repeat (n - 1) ln.push_back(solid_octet(1'b0));
      // Occasionally enough parameters to run the index into saturation.
      n_par = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
      repeat (n_par) begin
        ln.push_back(CH_SPACE);
        n = $urandom_range(0, 4);
        if (n != 0) begin
          ln.push_back(solid_octet(1'b1));
          repeat (n - 1) ln.push_back(solid_octet(1'b0));
        end
      end
      if ($urandom_range(0, 99) < 40) begin
        ln.push_back(CH_SPACE);
        ln.push_back(CH_COLON);
        n = $urandom_range(0, 6);
        repeat (n) begin
          ln.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE : 8'($urandom_range(0, 255)));
        end
      end
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0:       ln.push_back(CH_COLON);
          1:       ln.push_back(CH_SPACE);
          default: ln.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    foreach (ln[i]) push_octet(ln[i], i == ln.size() - 1);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      mism_cnt++;
      if (mism_cnt <= 10) $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Input driver: predicts each accepted octet and offers the next one.
  always @(posedge clk) begin : drv
    line_octet_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        class_q.push_back(classify_octet(s_tdata, s_tlast));
        accepted++;
      end
      // Halfway through, let every pending result drain before going on.
      if (!pause_done && accepted >= n_total / 2) begin
        pausing    = 1'b1;
        pause_done = 1'b1;
      end
      if (pausing && class_q.size() == 0) pausing = 1'b0;
      if (!s_tvalid || s_tready) begin
        if (line_q.size() != 0 && !pausing && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          item = line_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= item.octet;
          s_tlast  <= item.eol;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output ready, with one long hold-off late in the run.
  always @(posedge clk) begin : rcv
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && accepted >= 3 * n_total / 4) begin
        hold_cycles = HOLD_CYCLES;
        hold_done   = 1'b1;
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
    end
  end

  // Result checker against the oldest expected classification.
  always @(posedge clk) begin : mon
    octet_class_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (class_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10) $display("unexpected result: tdata %h tuser %h", m_tdata, m_tuser);
      end else begin
        want = class_q.pop_front();
        check_field("byte_out", m_tdata[7:0], want.octet);
        check_field("param_index", m_tdata[11:8], want.pidx);
        check_field("tdata padding", m_tdata[15:12], 0);
        check_field("byte_class", m_tuser[2:0], want.cls);
        check_field("field_end", m_tuser[3], want.fend);
        check_field("line_ok", m_tuser[4], want.ok);
        check_field("last", m_tlast, want.eol);
      end
    end
  end

  // Run watchdog.
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // Prefix, empty command, trailing with a space, ending mid-trailing.
    push_text(":p  :a b");
    // A lone space: empty command closed at line start.
    push_text(" ");
    // Prefix that runs to the end of the line.
    push_octet(CH_COLON, 1'b0);
    push_octet(8'hFF, 1'b1);
    // Empty parameters past the index limit, then a middle at line end.
    push_octet(8'h43, 1'b0);
    repeat (17) push_octet(CH_SPACE, 1'b0);
    push_octet(8'h00, 1'b1);
    while (line_q.size() < 1850) push_random_line();
    n_total = line_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (!(accepted == n_total && class_q.size() == 0)) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mism_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/irc_tok_pkg.sv
rtl/irc_message_tokenizer_top.sv
tb/sv/testbench.sv
